// ===== rtl/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types and constants for the SHA-512 stream hasher.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int unsigned NumRounds = 80;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned QueueDepth = 2;
    localparam logic [7:0] PadByte = 8'h80;

    // block handed from the front end to the compression engine
    typedef struct packed {
        logic [1023:0] data;
        logic          last;
    } t_block;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_eng_state;

    typedef enum logic [1:0] {
        FS_COLLECT,
        FS_PAD1,
        FS_PAD2
    } t_front_state;

    function automatic logic [63:0] round_k(input logic [6:0] idx);
        logic [63:0] k;
        case (idx)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] init_hash(input logic [2:0] idx);
        logic [63:0] h;
        case (idx)
            3'd0: h = 64'h6a09e667f3bcc908;
            3'd1: h = 64'hbb67ae8584caa73b;
            3'd2: h = 64'h3c6ef372fe94f82b;
            3'd3: h = 64'ha54ff53a5f1d36f1;
            3'd4: h = 64'h510e527fade682d1;
            3'd5: h = 64'h9b05688c2b3e6c1f;
            3'd6: h = 64'h1f83d9abfb41bd6b;
            3'd7: h = 64'h5be0cd19137e2179;
            default: h = '0;
        endcase
        return h;
    endfunction

endpackage

// ===== rtl/sha512_front.sv =====
// ----------------------------------------------------------------------------
// sha512_front
// Packs message bytes into 1024-bit blocks, appends padding and length.
// ----------------------------------------------------------------------------
module sha512_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_has_byte,
    input  logic                 i_eom,
    output logic                 o_blk_valid,
    input  logic                 i_blk_ready,
    output sha512_pkg::t_block   o_blk
);

    sha512_pkg::t_front_state r_state, n_state;
    logic [1023:0] r_buf, n_buf;
    logic [6:0]    r_fill, n_fill;
    logic [63:0]   r_bits, n_bits;
    logic [63:0]   r_len, n_len;
    logic          r_two, n_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha512_pkg::FS_COLLECT;
            r_fill  <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
        end
        r_buf <= n_buf;
        r_len <= n_len;
        r_two <= n_two;
    end

    // byte k of the block sits at bits 1023-8k -: 8
    function automatic logic [1023:0] put_byte(input logic [1023:0] b,
                                               input logic [6:0] pos,
                                               input logic [7:0] v);
        logic [1023:0] r;
        r = b;
        r[10'd1023 - {pos, 3'b000} -: 8] = v;
        return r;
    endfunction

    // clear every byte from pos on; pos wraps to 0 past the last byte: keep all
    function automatic logic [1023:0] clear_from(input logic [1023:0] b,
                                                 input logic [6:0] pos);
        logic [1023:0] mask;
        mask = ~({1024{1'b1}} >> {pos, 3'b000});
        if (pos == 7'd0) mask = '1;
        return b & mask;
    endfunction

    logic [6:0]  w_fill1;
    logic [1023:0] w_buf1;
    logic        w_full;

    always_comb begin
        n_state     = r_state;
        n_buf       = r_buf;
        n_fill      = r_fill;
        n_bits      = r_bits;
        n_len       = r_len;
        n_two       = r_two;
        o_ready     = 1'b0;
        o_blk_valid = 1'b0;
        o_blk.data  = r_buf;
        o_blk.last  = 1'b0;
        w_buf1      = i_has_byte ? put_byte(r_buf, r_fill, i_byte) : r_buf;
        w_fill1     = i_has_byte ? r_fill + 7'd1 : r_fill;
        w_full      = i_has_byte && (r_fill == 7'd127);
        case (r_state)
            sha512_pkg::FS_COLLECT: begin
                // a full block goes out directly; the queue must be able to take it
                o_ready = i_blk_ready || !(w_full);
                if (i_valid && w_full) begin
                    o_ready = i_blk_ready;
                    o_blk_valid = 1'b1;
                    o_blk.data = w_buf1;
                end
                if (i_valid && o_ready) begin
                    n_buf  = w_buf1;
                    n_fill = w_fill1;
                    if (w_full) n_bits = r_bits + 64'd1024;
                    if (i_eom) begin
                        n_len = (w_full ? r_bits + 64'd1024 : r_bits)
                              + {54'd0, w_fill1, 3'b000};
                        n_buf = clear_from(put_byte(w_buf1, w_fill1, sha512_pkg::PadByte),
                                           w_fill1 + 7'd1);
                        if (w_fill1 == 7'd127) n_buf[0 +: 8] = sha512_pkg::PadByte;
                        n_two   = (w_fill1 > 7'd111);
                        n_state = sha512_pkg::FS_PAD1;
                    end
                end
            end
            sha512_pkg::FS_PAD1: begin
                o_blk_valid = 1'b1;
                o_blk.data  = r_two ? r_buf : {r_buf[1023:64], r_len};
                o_blk.last  = !r_two;
                if (i_blk_ready) begin
                    if (r_two) begin
                        n_buf   = '0;
                        n_state = sha512_pkg::FS_PAD2;
                    end else begin
                        n_fill  = '0;
                        n_bits  = '0;
                        n_state = sha512_pkg::FS_COLLECT;
                    end
                end
            end
            sha512_pkg::FS_PAD2: begin
                o_blk_valid = 1'b1;
                o_blk.data  = {960'd0, r_len};
                o_blk.last  = 1'b1;
                if (i_blk_ready) begin
                    n_fill  = '0;
                    n_bits  = '0;
                    n_state = sha512_pkg::FS_COLLECT;
                end
            end
            default: n_state = sha512_pkg::FS_COLLECT;
        endcase
    end

endmodule

// ===== rtl/sha512_queue.sv =====
// ----------------------------------------------------------------------------
// sha512_queue
// Two-entry block queue between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sha512_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sha512_pkg::t_block   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sha512_pkg::t_block   o_data
);

    sha512_pkg::t_block r_mem [sha512_pkg::QueueDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'(sha512_pkg::QueueDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(sha512_pkg::QueueDepth)) else $error("queue count overflow");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(sha512_pkg::QueueDepth)) |-> !o_ready) else $error("ready while full");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1)) else $error("count step");

endmodule

// ===== rtl/sha512_engine.sv =====
// ----------------------------------------------------------------------------
// sha512_engine
// One SHA-512 round per cycle; emits the digest after the last block.
// ----------------------------------------------------------------------------
module sha512_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sha512_pkg::t_block   i_blk,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [63:0]          o_word,
    output logic [2:0]           o_index,
    output logic                 o_last
);

    sha512_pkg::t_eng_state r_state, n_state;
    logic [63:0] r_h [8];
    logic [63:0] r_v [8];
    logic [63:0] r_w [sha512_pkg::BlockWords];
    logic [6:0]  r_rnd;
    logic        r_last;
    logic [2:0]  r_idx;

    function automatic logic [63:0] ror(input logic [63:0] x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    logic [63:0] w_t1, w_t2, w_s0, w_s1, w_wnext, w_e, w_a;
    assign w_e  = r_v[4];
    assign w_a  = r_v[0];
    assign w_t1 = r_v[7] + (ror(w_e, 14) ^ ror(w_e, 18) ^ ror(w_e, 41))
                + ((w_e & r_v[5]) ^ (~w_e & r_v[6])) + sha512_pkg::round_k(r_rnd) + r_w[0];
    assign w_t2 = (ror(w_a, 28) ^ ror(w_a, 34) ^ ror(w_a, 39))
                + ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_s0 = ror(r_w[1], 1) ^ ror(r_w[1], 8) ^ (r_w[1] >> 7);
    assign w_s1 = ror(r_w[14], 19) ^ ror(r_w[14], 61) ^ (r_w[14] >> 6);
    assign w_wnext = w_s1 + r_w[9] + w_s0 + r_w[0];

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            sha512_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = sha512_pkg::ST_ROUND;
            end
            sha512_pkg::ST_ROUND: begin
                if (r_rnd == 7'(sha512_pkg::NumRounds - 1)) n_state = sha512_pkg::ST_ADD;
            end
            sha512_pkg::ST_ADD: n_state = r_last ? sha512_pkg::ST_EMIT : sha512_pkg::ST_IDLE;
            sha512_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                if (i_ready && r_idx == 3'd7) n_state = sha512_pkg::ST_IDLE;
            end
            default: n_state = sha512_pkg::ST_IDLE;
        endcase
    end

    assign o_word  = r_h[r_idx];
    assign o_index = r_idx;
    assign o_last  = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha512_pkg::ST_IDLE;
            r_idx   <= '0;
            r_rnd   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha512_pkg::init_hash(3'(i));
        end else begin
            r_state <= n_state;
            case (r_state)
                sha512_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_rnd  <= '0;
                        r_last <= i_blk.last;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        for (int i = 0; i < 16; i++)
                            r_w[i] <= i_blk.data[1023 - 64*i -: 64];
                    end
                end
                sha512_pkg::ST_ROUND: begin
                    r_rnd <= r_rnd + 7'd1;
                    r_v[0] <= w_t1 + w_t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_wnext;
                end
                sha512_pkg::ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_idx <= '0;
                end
                sha512_pkg::ST_EMIT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7)
                            for (int i = 0; i < 8; i++) r_h[i] <= sha512_pkg::init_hash(3'(i));
                    end
                end
                default: ;
            endcase
        end
    end

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accepting block while emitting");
    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha512_pkg::ST_ADD) |-> (r_rnd == 7'(sha512_pkg::NumRounds)))
        else $error("round count");
    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> (r_h[0] == sha512_pkg::init_hash(3'd0)))
        else $error("chain not reset after digest");

endmodule

// ===== rtl/sha512_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha512_stream_hasher_core
// SHA-512 over a byte stream; digest out as eight 64-bit words.
// ----------------------------------------------------------------------------
// Byte beats are taken one per cycle while the front end collects a 128-byte
// block; a beat with no byte and no end is taken and changes nothing.
// Each block passes the compression engine as one load, 80 rounds at one round
// per cycle and one chain add, done before the front end can collect the next
// block, and a two-block queue sits in between, so long messages stream at one
// byte beat per cycle. Outside end-of-message padding, the input stalls only
// when the beat that completes a block finds the queue full. An end-of-message
// beat holds the input while one or two padding blocks go out, plus any wait
// for queue room; the first digest beat follows the rounds and chain add of the
// last block; the engine takes no new block until the sink has all eight beats.
module sha512_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] msg_byte
    input  logic        s_axis_tuser,  // has_byte
    input  logic        s_axis_tlast,  // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [63:0] digest_word
    output logic [2:0]  m_axis_tuser,  // [2:0] word_index
    output logic        m_axis_tlast   // last_word
);

    sha512_pkg::t_block w_fblk, w_qblk;
    logic w_fvalid, w_fready, w_qvalid, w_qready;

    sha512_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_has_byte(s_axis_tuser), .i_eom(s_axis_tlast),
        .o_blk_valid(w_fvalid), .i_blk_ready(w_fready), .o_blk(w_fblk)
    );

    sha512_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fvalid), .o_ready(w_fready), .i_data(w_fblk),
        .o_valid(w_qvalid), .i_ready(w_qready), .o_data(w_qblk)
    );

    sha512_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qvalid), .o_ready(w_qready), .i_blk(w_qblk),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(m_axis_tdata), .o_index(m_axis_tuser), .o_last(m_axis_tlast)
    );

endmodule
